### rtl/pbh_pkg.sv
// Shared types and constants of the particle box histogram.
// Used by the controller, the datapath and the top level; depends on nothing.

package pbh_pkg;

    // Default grid size on each axis.
    localparam int unsigned BOXES_X_DEF = 16;
    localparam int unsigned BOXES_Y_DEF = 16;
    localparam int unsigned BOXES_Z_DEF = 16;

    // Fixed field widths.
    localparam int unsigned POS_W   = 32;
    localparam int unsigned INV_W   = 24;
    localparam int unsigned BOX_W   = 12;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned DIFF_W  = POS_W + 1;
    localparam int unsigned PROD_W  = DIFF_W + INV_W;
    localparam int unsigned FRAC_W  = 24;
    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LOW_X  = 3'd0,
        CFG_BOX_LOW_Y  = 3'd1,
        CFG_BOX_LOW_Z  = 3'd2,
        CFG_INV_SIZE_X = 3'd3,
        CFG_INV_SIZE_Y = 3'd4,
        CFG_INV_SIZE_Z = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_INDEX,
        ST_READ,
        ST_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
        logic index;
        logic read;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

### rtl/pbh_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; depends on nothing.

module pbh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pbh_ctrl.sv
// Controller state machine of the particle box histogram.
// Depends on pbh_pkg for the state, command and status types.

module pbh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pbh_pkg::status_t  status,
    output pbh_pkg::cmd_t     cmd
);

    pbh_pkg::state_t state_reg;
    pbh_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbh_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbh_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = pbh_pkg::ST_IDLE;
                end
            end
            pbh_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = pbh_pkg::ST_MUL;
                end
            end
            pbh_pkg::ST_MUL:    state_next = pbh_pkg::ST_INDEX;
            pbh_pkg::ST_INDEX:  state_next = pbh_pkg::ST_READ;
            pbh_pkg::ST_READ:   state_next = pbh_pkg::ST_COMMIT;
            pbh_pkg::ST_COMMIT:
            begin
                // The result waits here until the output register has room.
                if (status.out_free)
                begin
                    state_next = pbh_pkg::ST_IDLE;
                end
            end
            default:            state_next = pbh_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            pbh_pkg::ST_CLEAR:  cmd.clear = 1'b1;
            pbh_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            pbh_pkg::ST_MUL:    cmd.calc  = 1'b1;
            pbh_pkg::ST_INDEX:  cmd.index = 1'b1;
            pbh_pkg::ST_READ:   cmd.read  = 1'b1;
            pbh_pkg::ST_COMMIT: cmd.commit = status.out_free;
            default:            cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.calc, cmd.index, cmd.read, cmd.commit}))
        else $error("more than one datapath command at once");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result committed while the output register is full");

    a_load_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.calc)
        else $error("accepted transaction not followed by the multiply step");

    a_read_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> (state_reg == pbh_pkg::ST_COMMIT))
        else $error("memory read not followed by the write-back step");
`endif

endmodule

### rtl/pbh_datapath.sv
// Datapath of the particle box histogram: configuration, axis index math,
// count memory with clearing pass, and output register.
// Depends on pbh_pkg and pbh_ram.

module pbh_datapath #(
    parameter int unsigned BOXES_X = pbh_pkg::BOXES_X_DEF,
    parameter int unsigned BOXES_Y = pbh_pkg::BOXES_Y_DEF,
    parameter int unsigned BOXES_Z = pbh_pkg::BOXES_Z_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pbh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pbh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [pbh_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    output logic [pbh_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  pbh_pkg::cmd_t                      cmd,
    output pbh_pkg::status_t                   status
);

    localparam int unsigned NUM_BOXES = BOXES_X * BOXES_Y * BOXES_Z;
    localparam int unsigned AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int unsigned MAX_XY = (BOXES_X > BOXES_Y) ? BOXES_X : BOXES_Y;
    localparam int unsigned MAX_B  = (MAX_XY > BOXES_Z) ? MAX_XY : BOXES_Z;
    localparam int unsigned IW = (MAX_B > 1) ? $clog2(MAX_B) : 1;
    localparam int unsigned HI_W = pbh_pkg::PROD_W - pbh_pkg::FRAC_W;
    localparam logic [31:0] NUM_BOXES_V = 32'(NUM_BOXES);
    localparam logic [31:0] STRIDE_Y    = 32'(BOXES_X);
    localparam logic [31:0] STRIDE_Z    = 32'(BOXES_X * BOXES_Y);
    localparam logic [AW-1:0] LAST_BOX  = AW'(NUM_BOXES - 1);
    localparam logic [HI_W-1:0] AXIS_N [3] =
        '{HI_W'(BOXES_X), HI_W'(BOXES_Y), HI_W'(BOXES_Z)};
    localparam logic [pbh_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration registers.
    logic signed [pbh_pkg::POS_W-1:0] low_reg [3];
    logic [pbh_pkg::INV_W-1:0]        inv_reg [3];

    // Captured transaction.
    logic                             mode_reg;
    logic signed [pbh_pkg::POS_W-1:0] pos_reg [3];
    logic [pbh_pkg::BOX_W-1:0]        rbox_reg;

    // Multiply stage.
    logic [pbh_pkg::PROD_W-1:0]       prod_reg [3];
    logic [2:0]                       miss_reg;

    // Index stage.
    logic [AW-1:0]                    addr_reg;
    logic                             hit_reg;
    logic [pbh_pkg::BOX_W-1:0]        bidx_reg;

    logic [AW-1:0]                    clr_cnt_reg;
    logic                             out_valid_reg;
    logic [pbh_pkg::M_TDATA_W-1:0]    out_data_reg;
    logic                             out_hit_reg;

    logic [pbh_pkg::DIFF_W-1:0]       diff [3];
    logic [2:0]                       miss_next;
    logic [2:0]                       axis_ok;
    logic [IW-1:0]                    axis_idx [3];
    logic [31:0]                      flat_sum;
    logic [AW-1:0]                    flat;
    logic                             rb_in_range;
    logic [pbh_pkg::COUNT_W-1:0]      rdata;
    logic [pbh_pkg::COUNT_W-1:0]      new_count;
    logic [pbh_pkg::COUNT_W-1:0]      out_count;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [pbh_pkg::COUNT_W-1:0]      ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                low_reg[a] <= '0;
                inv_reg[a] <= pbh_pkg::INV_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbh_pkg::CFG_BOX_LOW_X:  low_reg[0] <= cfg_data;
                pbh_pkg::CFG_BOX_LOW_Y:  low_reg[1] <= cfg_data;
                pbh_pkg::CFG_BOX_LOW_Z:  low_reg[2] <= cfg_data;
                pbh_pkg::CFG_INV_SIZE_X: inv_reg[0] <= cfg_data[pbh_pkg::INV_W-1:0];
                pbh_pkg::CFG_INV_SIZE_Y: inv_reg[1] <= cfg_data[pbh_pkg::INV_W-1:0];
                pbh_pkg::CFG_INV_SIZE_Z: inv_reg[2] <= cfg_data[pbh_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // A coordinate misses when it is not positive or lies below its bound.
    // Otherwise the difference is non-negative and fits in 33 bits.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            miss_next[a] = (pos_reg[a] <= 0) || (pos_reg[a] < low_reg[a]);
            diff[a] = pbh_pkg::DIFF_W'({pos_reg[a][pbh_pkg::POS_W-1], pos_reg[a]})
                    - pbh_pkg::DIFF_W'({low_reg[a][pbh_pkg::POS_W-1], low_reg[a]});
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            axis_ok[a]  = !miss_reg[a]
                        && (prod_reg[a][pbh_pkg::PROD_W-1:pbh_pkg::FRAC_W] < AXIS_N[a]);
            axis_idx[a] = prod_reg[a][pbh_pkg::FRAC_W +: IW];
        end
        flat_sum = 32'(axis_idx[2]) * STRIDE_Z + 32'(axis_idx[1]) * STRIDE_Y
                 + 32'(axis_idx[0]);
        flat = flat_sum[AW-1:0];
        rb_in_range = 32'(rbox_reg) < NUM_BOXES_V;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= s_tuser;
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
            pos_reg[2] <= s_tdata[95:64];
            rbox_reg   <= s_tdata[107:96];
        end
        if (cmd.calc)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= pbh_pkg::PROD_W'(diff[a]) * pbh_pkg::PROD_W'(inv_reg[a]);
            end
            miss_reg <= miss_next;
        end
        if (cmd.index)
        begin
            if (mode_reg)
            begin
                addr_reg <= AW'(rbox_reg);
                hit_reg  <= rb_in_range;
                bidx_reg <= rbox_reg;
            end
            else
            begin
                addr_reg <= flat;
                hit_reg  <= &axis_ok;
                bidx_reg <= (&axis_ok) ? pbh_pkg::BOX_W'(flat) : '0;
            end
        end
    end

    pbh_ram #(
        .WIDTH (pbh_pkg::COUNT_W),
        .DEPTH (NUM_BOXES),
        .AW    (AW)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        if (mode_reg)
        begin
            new_count = '0;
        end
        else if (rdata == COUNT_MAX)
        begin
            new_count = rdata;
        end
        else
        begin
            new_count = rdata + 1'b1;
        end

        if (!hit_reg)
        begin
            out_count = '0;
        end
        else if (mode_reg)
        begin
            out_count = rdata;
        end
        else
        begin
            out_count = new_count;
        end

        ram_we    = cmd.clear || (cmd.commit && hit_reg);
        ram_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
        ram_wdata = cmd.clear ? '0 : new_count;
    end

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {4'b0, out_count, bidx_reg};
            out_hit_reg  <= hit_reg;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tvalid = out_valid_reg;

    assign status.clear_last = (clr_cnt_reg == LAST_BOX);
    assign status.out_free   = !out_valid_reg || m_tready;

`ifndef SYNTHESIS
    a_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg) |-> (32'(addr_reg) < NUM_BOXES_V))
        else $error("count write outside the grid");

    a_miss_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_reg) |=> (out_data_reg[pbh_pkg::BOX_W +: pbh_pkg::COUNT_W] == '0))
        else $error("missed transaction reports a nonzero count");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg && !mode_reg) |=> (out_data_reg[pbh_pkg::BOX_W +:
            pbh_pkg::COUNT_W] != '0))
        else $error("binned particle reports a zero count");
`endif

endmodule

### rtl/particle_box_histogram.sv
// Top level of the particle box histogram.
// Depends on pbh_pkg, pbh_ctrl, pbh_datapath (and through it pbh_ram).

// Counts particles per box of a BOXES_X x BOXES_Y x BOXES_Z grid. With tuser
// low a transaction carries a Q23.8 position; a hit increments that box's
// 32-bit count (saturating) and returns it. With tuser high it reads and
// clears the box named by read_box. An accepted transaction passes in order
// through one 33x24 multiply per axis, index and range check, count memory
// read and write-back, and is then presented in the output register; the
// write-back waits until the output register has room. The next transaction
// is accepted only after the write-back, so transactions are taken one at a
// time, as the single read-modify-write of the count memory requires. After
// reset a clearing pass zeroes the counts; no transaction is accepted during
// it, while configuration writes are taken at any time.

module particle_box_histogram #(
    parameter int unsigned BOXES_X = pbh_pkg::BOXES_X_DEF,
    parameter int unsigned BOXES_Y = pbh_pkg::BOXES_Y_DEF,
    parameter int unsigned BOXES_Z = pbh_pkg::BOXES_Z_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pbh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pbh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], read_box[107:96], zero fill
    input  logic [pbh_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // box_index[11:0], box_count[43:12], zero fill
    output logic [pbh_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit
    output logic                               m_tuser
);

    pbh_pkg::cmd_t    cmd;
    pbh_pkg::status_t status;

    pbh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbh_datapath #(
        .BOXES_X (BOXES_X),
        .BOXES_Y (BOXES_Y),
        .BOXES_Z (BOXES_Z)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
